@@ rtl/rfbcpx_pkg.sv @@
// Package for the RFB pixel to compressed-pixel converter.
// Holds register indexes, field widths, reset values and helper functions.
// No dependencies.
package rfbcpx_pkg;

  localparam int NUM_CH      = 3;
  localparam int SHIFT_W     = 5;
  localparam int MAX_W       = 16;
  localparam int WIDTH_W     = 5;   // popcount of a 16-bit max: 0..16
  localparam int PIXEL_W     = 32;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int BPP_W       = 6;
  localparam int COUNT_W     = 2;

  localparam logic [14:0] SHIFTS_RESET = 15'd16640;
  localparam logic [47:0] MAXES_RESET  = 48'h00FF_00FF_00FF;
  localparam logic [1:0]  BPC_RESET    = 2'd3;
  localparam logic [5:0]  BPP_RESET    = 6'd32;
  localparam logic [5:0]  BPP_FULL     = 6'd32;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 5'd8;

  // Byte-count modes.
  localparam logic [1:0] MODE_1B = 2'd1;
  localparam logic [1:0] MODE_2B = 2'd2;
  localparam logic [1:0] MODE_3B = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SRC_SHIFTS   = 3'd0,
    CFG_SRC_MAXES    = 3'd1,
    CFG_DST_SHIFTS   = 3'd2,
    CFG_DST_MAXES    = 3'd3,
    CFG_DST_BIG_END  = 3'd4,
    CFG_BYTES_PER_CP = 3'd5,
    CFG_DST_BPP      = 3'd6
  } cfg_idx_t;

  function automatic logic [WIDTH_W-1:0] ones16(input logic [MAX_W-1:0] v);
    logic [WIDTH_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_W; i++) begin
      n = n + WIDTH_W'(v[i]);
    end
    return n;
  endfunction

  // Channel 0 is red, held in the top field.
  function automatic logic [SHIFT_W-1:0] shift_of(input logic [14:0] packed_sh,
                                                  input int ch);
    return packed_sh[SHIFT_W*(NUM_CH-1-ch) +: SHIFT_W];
  endfunction

  function automatic logic [MAX_W-1:0] max_of(input logic [47:0] packed_mx,
                                              input int ch);
    return packed_mx[MAX_W*(NUM_CH-1-ch) +: MAX_W];
  endfunction

endpackage

@@ rtl/rfb_pixel_to_cpixel.sv @@
// RFB true-color pixel to compressed pixel (1 to 3 bytes) converter.
// Pipeline: the input register, then the result register; the result is registered.
// Throughput: one pixel per cycle; the input register also loads into a bubble while a
// result waits, and otherwise stalls with the result register.
// Reset (rst, synchronous, active high): registers return to 24-bit RGB 8:8:8 at shifts
// 16/8/0, little endian, 3 bytes per pixel, 32 bpp; both pipeline stages empty.
// Depends on rfbcpx_pkg.
module rfb_pixel_to_cpixel import rfbcpx_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [PIXEL_W-1:0]     pixel,
  input  logic                   last_in,
  // compressed pixel output
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             byte_0,
  output logic [7:0]             byte_1,
  output logic [7:0]             byte_2,
  output logic [COUNT_W-1:0]     byte_count,
  output logic                   last_out
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [14:0]      src_shifts;
  logic [47:0]      src_maxes;
  logic [14:0]      dst_shifts;
  logic [47:0]      dst_maxes;
  logic             dst_big_endian;
  logic [1:0]       cpx_bytes;
  logic [BPP_W-1:0] dst_bits_per_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_shifts         <= SHIFTS_RESET;
      src_maxes          <= MAXES_RESET;
      dst_shifts         <= SHIFTS_RESET;
      dst_maxes          <= MAXES_RESET;
      dst_big_endian     <= 1'b0;
      cpx_bytes          <= BPC_RESET;
      dst_bits_per_pixel <= BPP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_SHIFTS:   src_shifts         <= cfg_data[14:0];
        CFG_SRC_MAXES:    src_maxes          <= cfg_data[47:0];
        CFG_DST_SHIFTS:   dst_shifts         <= cfg_data[14:0];
        CFG_DST_MAXES:    dst_maxes          <= cfg_data[47:0];
        CFG_DST_BIG_END:  dst_big_endian     <= cfg_data[0];
        CFG_BYTES_PER_CP: cpx_bytes          <= cfg_data[1:0];
        CFG_DST_BPP:      dst_bits_per_pixel <= cfg_data[BPP_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Derived settings, registered from the config regs.
  // Keeps popcounts and the min-shift search off the pixel path.
  // ---------------------------------------------------------------
  logic [WIDTH_W-1:0] src_width      [NUM_CH];
  logic [WIDTH_W-1:0] dst_width      [NUM_CH];
  logic [SHIFT_W-1:0] dst_shift_eff  [NUM_CH];
  logic [1:0]         mode;

  logic [WIDTH_W-1:0] src_width_next [NUM_CH];
  logic [WIDTH_W-1:0] dst_width_next [NUM_CH];
  logic [SHIFT_W-1:0] dst_shift_next [NUM_CH];
  logic [1:0]         mode_next;
  logic [SHIFT_W-1:0] dsh_raw        [NUM_CH];
  logic [SHIFT_W-1:0] dsh_min;
  logic               normalize;

  always_comb begin
    // zero byte count behaves as 1-byte mode
    mode_next = (cpx_bytes == 2'd0) ? MODE_1B : cpx_bytes;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dsh_raw[ch]        = shift_of(dst_shifts, ch);
      src_width_next[ch] = ones16(max_of(src_maxes, ch));
      dst_width_next[ch] = ones16(max_of(dst_maxes, ch));
    end
    dsh_min = dsh_raw[0];
    if (dsh_min > dsh_raw[1]) dsh_min = dsh_raw[1];
    if (dsh_min > dsh_raw[2]) dsh_min = dsh_raw[2];
    // 3-byte packing of a 32 bpp format drops the unused low bits
    normalize = (mode_next == MODE_3B) && (dst_bits_per_pixel == BPP_FULL);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dst_shift_next[ch] = normalize ? (dsh_raw[ch] - dsh_min) : dsh_raw[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_3B;
      dst_shift_eff[0] <= SHIFTS_RESET[14:10];
      dst_shift_eff[1] <= SHIFTS_RESET[9:5];
      dst_shift_eff[2] <= SHIFTS_RESET[4:0];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        src_width[ch] <= WIDTH_RESET;
        dst_width[ch] <= WIDTH_RESET;
      end
    end else begin
      mode <= mode_next;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        src_width[ch]     <= src_width_next[ch];
        dst_width[ch]     <= dst_width_next[ch];
        dst_shift_eff[ch] <= dst_shift_next[ch];
      end
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: input register (s1) then result register.
  // ---------------------------------------------------------------
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic               s1_last;
  logic               out_take;   // result register can load
  logic               s1_take;    // input register can load

  assign out_take = !out_valid || out_ready;
  assign s1_take  = !s1_valid || out_take;
  assign in_ready = s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_pixel <= pixel;
      s1_last  <= last_in;
    end
  end

  // ---------------------------------------------------------------
  // Per-channel extract, rescale and place; bytes ordered per endian.
  // ---------------------------------------------------------------
  logic [PIXEL_W-1:0] ch_val [NUM_CH];
  logic [PIXEL_W-1:0] cpx;
  logic [7:0]         byte_0_next;
  logic [7:0]         byte_1_next;
  logic [7:0]         byte_2_next;

  always_comb begin
    cpx = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      ch_val[ch] = (s1_pixel >> shift_of(src_shifts, ch))
                   & {{(PIXEL_W-MAX_W){1'b0}}, max_of(src_maxes, ch)};
      ch_val[ch] = ch_val[ch] << dst_width[ch];
      ch_val[ch] = ch_val[ch] >> src_width[ch];
      ch_val[ch] = ch_val[ch] << dst_shift_eff[ch];
      cpx        = cpx | ch_val[ch];
    end

    byte_0_next = cpx[7:0];
    byte_1_next = 8'd0;
    byte_2_next = 8'd0;
    case (mode)
      MODE_3B: begin
        byte_0_next = dst_big_endian ? cpx[23:16] : cpx[7:0];
        byte_1_next = cpx[15:8];
        byte_2_next = dst_big_endian ? cpx[7:0] : cpx[23:16];
      end
      MODE_2B: begin
        byte_0_next = dst_big_endian ? cpx[15:8] : cpx[7:0];
        byte_1_next = dst_big_endian ? cpx[7:0] : cpx[15:8];
      end
      default: begin
        byte_0_next = cpx[7:0];
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      byte_0     <= byte_0_next;
      byte_1     <= byte_1_next;
      byte_2     <= byte_2_next;
      byte_count <= mode;
      last_out   <= s1_last;
    end
  end

endmodule
